// ===== design/qbt_pkg.sv =====
// ----------------------------------------------------------------------------
// qbt_pkg: shared types and constants of the word tokenizer
// Holds the item and result records, status codes, delimiter characters
// and the character class functions.
// ----------------------------------------------------------------------------
package qbt_pkg;

    localparam int BYTE_W = 8;
    localparam int WLEN_W = 12;
    localparam int STAT_W = 4;

    // Item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Characters that drive the quote, escape and bracket tracking
    localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_RND_OPEN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RND_CLOSE = 8'h29;
    localparam logic [BYTE_W-1:0] CH_CRL_OPEN  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_CRL_CLOSE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_SQR_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SQR_CLOSE = 8'h5D;

    // End-of-string status codes, in priority order
    typedef enum logic [STAT_W-1:0] {
        ST_OK             = 4'd0,
        ST_OPEN_DQUOTE    = 4'd1,
        ST_OPEN_SQUOTE    = 4'd2,
        ST_RND_CLOSE_MISS = 4'd3,
        ST_RND_OPEN_MISS  = 4'd4,
        ST_CRL_CLOSE_MISS = 4'd5,
        ST_CRL_OPEN_MISS  = 4'd6,
        ST_SQR_CLOSE_MISS = 4'd7,
        ST_SQR_OPEN_MISS  = 4'd8
    } status_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic              word_done;
        logic [WLEN_W-1:0] word_length;
        logic              delim_part;
        logic [BYTE_W-1:0] delim_byte;
        logic              string_done;
        status_t           status;
    } result_t;

    // C-locale whitespace: tab through carriage return, and space
    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // C-locale punctuation
    function automatic logic is_punct(input logic [BYTE_W-1:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

endpackage

// ===== design/qbt_if.sv =====
// ----------------------------------------------------------------------------
// qbt_in_if / qbt_out_if: request and result channels
// Valid/ready channels carrying one input request or one result.
// ----------------------------------------------------------------------------
interface qbt_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [qbt_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface qbt_out_if;
    logic                       valid;
    logic                       ready;
    logic                       word_done;
    logic [qbt_pkg::WLEN_W-1:0] word_length;
    logic                       delim_part;
    logic [qbt_pkg::BYTE_W-1:0] delim_byte;
    logic                       string_done;
    logic [qbt_pkg::STAT_W-1:0] status;

    modport source (output valid, output word_done, output word_length,
                    output delim_part, output delim_byte, output string_done,
                    output status, input ready);
    modport sink   (input valid, input word_done, input word_length,
                    input delim_part, input delim_byte, input string_done,
                    input status, output ready);
endinterface

// ===== design/quote_bracket_aware_word_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quote_bracket_aware_word_tokenizer: top level
// Splits a byte stream into word lengths and delimiter parts while tracking
// escapes, quotes and bracket depths.
//
//   Channel   | Dir | Carries
//   ----------+-----+-----------------------------------------------------
//   in_chan   | in  | kind, data_byte: one string byte or end marker
//   out_chan  | out | word_done, word_length, delim_part, delim_byte,
//             |     | string_done, status: one result per request
//
// One request per cycle sustained while out_chan is not stalled; each result
// passes the input register, then the result register, after its request is
// accepted. The state update between the two registers sets the rate.
// Reset clears all tracking state and both valid flags at once.
// While out_chan is stalled the result holds; one more request is
// buffered in the input register before in_chan.ready drops.
// ----------------------------------------------------------------------------
module quote_bracket_aware_word_tokenizer
#(
    parameter int MAX_WORD_LENGTH = 4095,
    parameter int DEPTH_BITS      = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    qbt_in_if.sink      in_chan,
    qbt_out_if.source   out_chan
);

    logic           item_valid;
    logic           take;
    qbt_pkg::item_t item;

    // Input register
    qbt_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_chan    (in_chan),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // State update and result register
    qbt_engine
    #(
        .MAX_WORD_LENGTH (MAX_WORD_LENGTH),
        .DEPTH_BITS      (DEPTH_BITS)
    )
    u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_chan   (out_chan)
    );

endmodule

// ===== design/qbt_in_stage.sv =====
// ----------------------------------------------------------------------------
// qbt_in_stage: input register
// Captures one request per cycle while free, held until the engine takes it.
// ----------------------------------------------------------------------------
module qbt_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    qbt_in_if.sink          in_chan,
    input  logic            take,
    output logic            item_valid,
    output qbt_pkg::item_t  item
);

    logic           valid_reg;
    logic           valid_next;
    qbt_pkg::item_t item_reg;
    logic           load;

    // Free when empty or when the held request moves on this cycle
    assign in_chan.ready = !valid_reg || take;
    assign load          = in_chan.valid && in_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.kind      <= in_chan.kind;
            item_reg.data_byte <= in_chan.data_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/qbt_engine.sv =====
// ----------------------------------------------------------------------------
// qbt_engine: tokenizer state and result register
// Updates quote, escape, bracket and word state for one request per cycle
// while the result register is free or read, and registers the result.
// ----------------------------------------------------------------------------
module qbt_engine
#(
    parameter int MAX_WORD_LENGTH = 4095,
    parameter int DEPTH_BITS      = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  qbt_pkg::item_t  item,
    output logic            take,
    qbt_out_if.source       out_chan
);

    localparam int CNT_W = $clog2(MAX_WORD_LENGTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WORD_LENGTH);
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

    // Tracking state
    logic                         esc_reg,  esc_next;
    logic                         qjo_reg,  qjo_next;
    logic                         dq_reg,   dq_next;
    logic                         sq_reg,   sq_next;
    logic signed [DEPTH_BITS-1:0] rnd_reg,  rnd_next;
    logic signed [DEPTH_BITS-1:0] crl_reg,  crl_next;
    logic signed [DEPTH_BITS-1:0] sqr_reg,  sqr_next;
    logic [CNT_W-1:0]             cnt_reg,  cnt_next;
    logic                         wss_reg,  wss_next;
    logic                         last_reg, last_next;
    logic                         any_reg,  any_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    qbt_pkg::result_t  res_reg, res_next;

    logic [qbt_pkg::BYTE_W-1:0] c;
    logic                       c_space;
    logic                       c_delim;
    logic                       emit;

    function automatic logic signed [DEPTH_BITS-1:0] depth_up(
        input logic signed [DEPTH_BITS-1:0] d);
        return (d != DEPTH_MAX) ? d + DEPTH_ONE : d;
    endfunction

    function automatic logic signed [DEPTH_BITS-1:0] depth_down(
        input logic signed [DEPTH_BITS-1:0] d);
        return (d != DEPTH_MIN) ? d - DEPTH_ONE : d;
    endfunction

    assign take    = item_valid && (!out_valid_reg || out_chan.ready);
    assign c       = item.data_byte;
    assign c_space = qbt_pkg::is_space(c);
    assign c_delim = c_space || qbt_pkg::is_punct(c);

    // Next state and result for the request in the input register
    always_comb
    begin
        esc_next  = esc_reg;
        qjo_next  = qjo_reg;
        dq_next   = dq_reg;
        sq_next   = sq_reg;
        rnd_next  = rnd_reg;
        crl_next  = crl_reg;
        sqr_next  = sqr_reg;
        cnt_next  = cnt_reg;
        wss_next  = wss_reg;
        last_next = last_reg;
        any_next  = any_reg;
        emit      = 1'b0;
        res_next  = '0;
        res_next.status = qbt_pkg::ST_OK;

        if (item.kind == qbt_pkg::KIND_END)
        begin
            // Flush the open word, report status, return to reset state
            res_next.word_done   = (cnt_reg != '0);
            res_next.word_length = (cnt_reg != '0) ? qbt_pkg::WLEN_W'(cnt_reg) : '0;
            res_next.string_done = 1'b1;
            if (dq_reg)
                res_next.status = qbt_pkg::ST_OPEN_DQUOTE;
            else if (sq_reg)
                res_next.status = qbt_pkg::ST_OPEN_SQUOTE;
            else if (rnd_reg > 0)
                res_next.status = qbt_pkg::ST_RND_CLOSE_MISS;
            else if (rnd_reg < 0)
                res_next.status = qbt_pkg::ST_RND_OPEN_MISS;
            else if (crl_reg > 0)
                res_next.status = qbt_pkg::ST_CRL_CLOSE_MISS;
            else if (crl_reg < 0)
                res_next.status = qbt_pkg::ST_CRL_OPEN_MISS;
            else if (sqr_reg > 0)
                res_next.status = qbt_pkg::ST_SQR_CLOSE_MISS;
            else if (sqr_reg < 0)
                res_next.status = qbt_pkg::ST_SQR_OPEN_MISS;
            esc_next  = 1'b0;
            qjo_next  = 1'b0;
            dq_next   = 1'b0;
            sq_next   = 1'b0;
            rnd_next  = '0;
            crl_next  = '0;
            sqr_next  = '0;
            cnt_next  = '0;
            wss_next  = 1'b0;
            last_next = 1'b0;
            any_next  = 1'b0;
        end
        else
        begin
            // Quote and bracket tracking, skipped for an escaped byte
            if (!esc_reg)
            begin
                qjo_next = 1'b0;
                if (!sq_reg && c == qbt_pkg::CH_DQUOTE)
                begin
                    dq_next  = !dq_reg;
                    qjo_next = !dq_reg;
                end
                if (!dq_next && c == qbt_pkg::CH_SQUOTE)
                begin
                    sq_next  = !sq_reg;
                    qjo_next = !sq_reg;
                end
                if (!(dq_next || sq_next))
                begin
                    case (c)
                        qbt_pkg::CH_RND_OPEN:  rnd_next = depth_up(rnd_reg);
                        qbt_pkg::CH_RND_CLOSE: rnd_next = depth_down(rnd_reg);
                        qbt_pkg::CH_CRL_OPEN:  crl_next = depth_up(crl_reg);
                        qbt_pkg::CH_CRL_CLOSE: crl_next = depth_down(crl_reg);
                        qbt_pkg::CH_SQR_OPEN:  sqr_next = depth_up(sqr_reg);
                        qbt_pkg::CH_SQR_CLOSE: sqr_next = depth_down(sqr_reg);
                        default: ;
                    endcase
                end
            end

            if (!esc_reg && c == qbt_pkg::CH_BACKSLASH)
            begin
                // Backslash starts an escape and is part of the word
                esc_next = 1'b1;
                if (cnt_reg == '0)
                    wss_next = c_space;
                if (cnt_reg != CNT_MAX)
                    cnt_next = cnt_reg + 1'b1;
            end
            else if (((!dq_next && !sq_next) || qjo_next) && c_delim)
            begin
                esc_next = 1'b0;
                // Close the current word
                if (cnt_reg != '0)
                begin
                    res_next.word_done   = 1'b1;
                    res_next.word_length = qbt_pkg::WLEN_W'(cnt_reg);
                    last_next = wss_reg;
                    any_next  = 1'b1;
                    cnt_next  = '0;
                    wss_next  = 1'b0;
                end
                // Report the delimiter unless it is redundant whitespace
                if (!any_next)
                    emit = !c_space;
                else
                    emit = !(last_next && c_space);
                if (emit)
                begin
                    res_next.delim_part = 1'b1;
                    res_next.delim_byte = c;
                    last_next = c_space;
                    any_next  = 1'b1;
                end
            end
            else
            begin
                esc_next = 1'b0;
                if (cnt_reg == '0)
                    wss_next = c_space;
                if (cnt_reg != CNT_MAX)
                    cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Result valid follows the handshake on both sides
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (out_chan.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= 1'b0;
            qjo_reg       <= 1'b0;
            dq_reg        <= 1'b0;
            sq_reg        <= 1'b0;
            rnd_reg       <= '0;
            crl_reg       <= '0;
            sqr_reg       <= '0;
            cnt_reg       <= '0;
            wss_reg       <= 1'b0;
            last_reg      <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                esc_reg  <= esc_next;
                qjo_reg  <= qjo_next;
                dq_reg   <= dq_next;
                sq_reg   <= sq_next;
                rnd_reg  <= rnd_next;
                crl_reg  <= crl_next;
                sqr_reg  <= sqr_next;
                cnt_reg  <= cnt_next;
                wss_reg  <= wss_next;
                last_reg <= last_next;
                any_reg  <= any_next;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign out_chan.valid       = out_valid_reg;
    assign out_chan.word_done   = res_reg.word_done;
    assign out_chan.word_length = res_reg.word_length;
    assign out_chan.delim_part  = res_reg.delim_part;
    assign out_chan.delim_byte  = res_reg.delim_byte;
    assign out_chan.string_done = res_reg.string_done;
    assign out_chan.status      = res_reg.status;

    // An end request leaves all tracking state cleared
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.kind == qbt_pkg::KIND_END) |=>
            (cnt_reg == '0 && !dq_reg && !sq_reg && !esc_reg && !any_reg))
        else $error("state not cleared after end of string");

    // A pending escape never coexists with a freshly opened quote
    a_esc_qjo: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> !qjo_reg)
        else $error("escape pending with quote just opened");

    // An end result never carries a delimiter part
    a_end_no_delim: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.string_done) |-> !res_reg.delim_part)
        else $error("delimiter reported on end of string");

    // A data result always reports ok status
    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.string_done) |-> res_reg.status == qbt_pkg::ST_OK)
        else $error("status set on a data byte result");

    // A held result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_chan.ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("result changed while stalled");

endmodule

// ===== test/quote_bracket_aware_word_tokenizer_test.sv =====
// ----------------------------------------------------------------------------
// quote_bracket_aware_word_tokenizer_test: self-checking testbench
// Feeds byte strings and end markers into the tokenizer and predicts every
// result in step with the accepted requests. A short directed part covers
// quoting, escapes, status codes and leading or repeated whitespace. Random
// strings follow, mostly well formed, with some broken ones and some noise.
// Saturated bracket depths are reached on purpose. Idling on both channels
// varies by phase.
// ----------------------------------------------------------------------------
module quote_bracket_aware_word_tokenizer_test;

    localparam int BW       = qbt_pkg::BYTE_W;
    localparam int DEPTH_W  = 8;
    localparam int MAX_WLEN = 4095;
    localparam logic signed [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(2 ** (DEPTH_W - 1) - 1);
    localparam logic signed [DEPTH_W-1:0] DEPTH_BOT = DEPTH_W'(-(2 ** (DEPTH_W - 1)));

    // Styles of random strings
    localparam int STYLE_CLEAN  = 0;
    localparam int STYLE_BROKEN = 1;
    localparam int STYLE_NOISE  = 2;

    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 100;

    logic clk;
    logic rst_n;

    qbt_in_if  in_if ();
    qbt_out_if out_if ();

    quote_bracket_aware_word_tokenizer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_if),
        .out_chan (out_if)
    );

    // Request and token bookkeeping
    qbt_pkg::item_t   requests_to_send[$];
    qbt_pkg::result_t tokens_due[$];
    int      requests_sent;
    int      requests_taken;
    logic    req_taken;
    int      src_idle_pct;
    int      out_stall_pct;
    int      mismatches;

    // Tokenizer state as predicted
    logic                       esc_pend;
    logic                       quote_opened;
    logic                       in_dq;
    logic                       in_sq;
    logic signed [DEPTH_W-1:0]  rnd_depth;
    logic signed [DEPTH_W-1:0]  crl_depth;
    logic signed [DEPTH_W-1:0]  sqr_depth;
    logic [qbt_pkg::WLEN_W-1:0] word_len;
    logic                       word_sp;
    logic                       last_sp;
    logic                       part_seen;

    string punct_set = "!#$%&*+,-./:;<=>?@^_`|~";
    logic [BW-1:0] stray_set[9] = '{qbt_pkg::CH_DQUOTE, qbt_pkg::CH_SQUOTE,
                                    qbt_pkg::CH_BACKSLASH, qbt_pkg::CH_RND_OPEN,
                                    qbt_pkg::CH_RND_CLOSE, qbt_pkg::CH_CRL_OPEN,
                                    qbt_pkg::CH_CRL_CLOSE, qbt_pkg::CH_SQR_OPEN,
                                    qbt_pkg::CH_SQR_CLOSE};
    logic [BW-1:0] opener_set[3] = '{qbt_pkg::CH_RND_OPEN, qbt_pkg::CH_CRL_OPEN,
                                     qbt_pkg::CH_SQR_OPEN};
    logic [BW-1:0] closer_set[3] = '{qbt_pkg::CH_RND_CLOSE, qbt_pkg::CH_CRL_CLOSE,
                                     qbt_pkg::CH_SQR_CLOSE};

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset, released at a falling edge with a nonblocking assignment
    initial
    begin
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.kind = qbt_pkg::KIND_DATA;
        in_if.data_byte = '0;
        out_if.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Whitespace and punctuation classes of the C locale
    function automatic logic blank_byte(input logic [BW-1:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic mark_byte(input logic [BW-1:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    // Signed bracket depth step with saturation
    function automatic logic signed [DEPTH_W-1:0] nudge(
        input logic signed [DEPTH_W-1:0] d, input logic up);
        if (up)
            return (d == DEPTH_TOP) ? d : DEPTH_W'(d + 1);
        return (d == DEPTH_BOT) ? d : DEPTH_W'(d - 1);
    endfunction

    function automatic void clear_state();
        esc_pend = 1'b0;
        quote_opened = 1'b0;
        in_dq = 1'b0;
        in_sq = 1'b0;
        rnd_depth = '0;
        crl_depth = '0;
        sqr_depth = '0;
        word_len = '0;
        word_sp = 1'b0;
        last_sp = 1'b0;
        part_seen = 1'b0;
    endfunction

    // Status of the end marker, highest priority first
    function automatic qbt_pkg::status_t open_status();
        if (in_dq)         return qbt_pkg::ST_OPEN_DQUOTE;
        if (in_sq)         return qbt_pkg::ST_OPEN_SQUOTE;
        if (rnd_depth > 0) return qbt_pkg::ST_RND_CLOSE_MISS;
        if (rnd_depth < 0) return qbt_pkg::ST_RND_OPEN_MISS;
        if (crl_depth > 0) return qbt_pkg::ST_CRL_CLOSE_MISS;
        if (crl_depth < 0) return qbt_pkg::ST_CRL_OPEN_MISS;
        if (sqr_depth > 0) return qbt_pkg::ST_SQR_CLOSE_MISS;
        if (sqr_depth < 0) return qbt_pkg::ST_SQR_OPEN_MISS;
        return qbt_pkg::ST_OK;
    endfunction

    function automatic void grow_word(input logic [BW-1:0] c);
        if (word_len == 0)
            word_sp = blank_byte(c);
        if (word_len < MAX_WLEN)
            word_len = word_len + 1'b1;
    endfunction

    // Predicts the token of one accepted request and advances the state
    function automatic qbt_pkg::result_t tokenize_byte(input logic kind,
                                                       input logic [BW-1:0] c);
        qbt_pkg::result_t r;
        logic             sp;
        logic             show;
        r = '0;
        if (kind == qbt_pkg::KIND_END)
        begin
            if (word_len != 0)
            begin
                r.word_done = 1'b1;
                r.word_length = word_len;
            end
            r.string_done = 1'b1;
            r.status = open_status();
            clear_state();
            return r;
        end

        // Quote and bracket tracking is skipped for an escaped byte
        if (!esc_pend)
        begin
            quote_opened = 1'b0;
            if (!in_sq && c == qbt_pkg::CH_DQUOTE)
            begin
                in_dq = !in_dq;
                quote_opened = in_dq;
            end
            if (!in_dq && c == qbt_pkg::CH_SQUOTE)
            begin
                in_sq = !in_sq;
                quote_opened = in_sq;
            end
            if (!in_dq && !in_sq)
            begin
                case (c)
                    qbt_pkg::CH_RND_OPEN:  rnd_depth = nudge(rnd_depth, 1'b1);
                    qbt_pkg::CH_RND_CLOSE: rnd_depth = nudge(rnd_depth, 1'b0);
                    qbt_pkg::CH_CRL_OPEN:  crl_depth = nudge(crl_depth, 1'b1);
                    qbt_pkg::CH_CRL_CLOSE: crl_depth = nudge(crl_depth, 1'b0);
                    qbt_pkg::CH_SQR_OPEN:  sqr_depth = nudge(sqr_depth, 1'b1);
                    qbt_pkg::CH_SQR_CLOSE: sqr_depth = nudge(sqr_depth, 1'b0);
                    default: ;
                endcase
            end
            if (c == qbt_pkg::CH_BACKSLASH)
            begin
                esc_pend = 1'b1;
                grow_word(c);
                return r;
            end
        end
        esc_pend = 1'b0;

        // Delimiters close the word and may stand as a part of their own
        if (((!in_dq && !in_sq) || quote_opened) && (blank_byte(c) || mark_byte(c)))
        begin
            sp = blank_byte(c);
            if (word_len != 0)
            begin
                r.word_done = 1'b1;
                r.word_length = word_len;
                last_sp = word_sp;
                part_seen = 1'b1;
                word_len = '0;
                word_sp = 1'b0;
            end
            show = part_seen ? !(last_sp && sp) : !sp;
            if (show)
            begin
                r.delim_part = 1'b1;
                r.delim_byte = c;
                last_sp = sp;
                part_seen = 1'b1;
            end
        end
        else
        begin
            grow_word(c);
        end
        return r;
    endfunction

    // Request side: predict on every accepted request
    always @(posedge clk)
    begin
        req_taken = rst_n && ((in_if.valid && in_if.ready) === 1'b1);
        if (req_taken)
        begin
            tokens_due.push_back(tokenize_byte(in_if.kind, in_if.data_byte));
            requests_taken++;
        end
    end

    // Driver: a new request after the last one was taken, with random gaps
    always @(negedge clk)
    begin
        qbt_pkg::item_t nxt;
        if (rst_n && (!in_if.valid || req_taken))
        begin
            if (requests_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                nxt = requests_to_send.pop_front();
                in_if.valid <= 1'b1;
                in_if.kind <= nxt.kind;
                in_if.data_byte <= nxt.data_byte;
            end
            else
            begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    function automatic void note_mismatch(input string what,
                                          input qbt_pkg::result_t want,
                                          input qbt_pkg::result_t got);
        if (mismatches < 10)
        begin
            $write("%s: want wd=%0d len=%0d dp=%0d db=%h sd=%0d st=%0d",
                   what, want.word_done, want.word_length, want.delim_part,
                   want.delim_byte, want.string_done, want.status);
            $display(" | got wd=%0d len=%0d dp=%0d db=%h sd=%0d st=%0d",
                     got.word_done, got.word_length, got.delim_part,
                     got.delim_byte, got.string_done, got.status);
        end
        mismatches++;
    endfunction

    // Monitor: compare every accepted token with the oldest prediction
    always @(posedge clk)
    begin
        qbt_pkg::result_t got;
        qbt_pkg::result_t want;
        if (rst_n && ((out_if.valid && out_if.ready) === 1'b1))
        begin
            got.word_done   = out_if.word_done;
            got.word_length = out_if.word_length;
            got.delim_part  = out_if.delim_part;
            got.delim_byte  = out_if.delim_byte;
            got.string_done = out_if.string_done;
            got.status      = qbt_pkg::status_t'(out_if.status);
            if (tokens_due.size() == 0)
            begin
                note_mismatch("unexpected token", '0, got);
            end
            else
            begin
                want = tokens_due.pop_front();
                if (got.word_done !== want.word_done ||
                    got.word_length !== want.word_length ||
                    got.delim_part !== want.delim_part ||
                    got.delim_byte !== want.delim_byte ||
                    got.string_done !== want.string_done ||
                    got.status !== want.status)
                    note_mismatch("token mismatch", want, got);
            end
        end
    end

    // Stimulus helpers
    task automatic push_byte(input logic [BW-1:0] c);
        qbt_pkg::item_t it;
        it.kind = qbt_pkg::KIND_DATA;
        it.data_byte = c;
        requests_to_send.push_back(it);
        requests_sent++;
    endtask

    task automatic push_end();
        qbt_pkg::item_t it;
        it.kind = qbt_pkg::KIND_END;
        it.data_byte = BW'($urandom_range(255));
        requests_to_send.push_back(it);
        requests_sent++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
        push_end();
    endtask

    // Bytes that are neither whitespace nor punctuation
    function automatic logic [BW-1:0] word_byte();
        case ($urandom_range(4))
            0: return BW'(8'h61 + $urandom_range(25));
            1: return BW'(8'h41 + $urandom_range(25));
            2: return BW'(8'h30 + $urandom_range(9));
            3: return BW'($urandom_range(255, 127));
            default: return BW'($urandom_range(1) ? $urandom_range(8)
                                                  : $urandom_range(31, 14));
        endcase
    endfunction

    function automatic logic [BW-1:0] blank_pick();
        return $urandom_range(5) == 5 ? 8'd32 : BW'($urandom_range(13, 9));
    endfunction

    function automatic logic [BW-1:0] mark_pick();
        return punct_set[$urandom_range(punct_set.len() - 1)];
    endfunction

    // One random string ended by an end marker
    task automatic push_phrase(input int style);
        logic [BW-1:0] closers[$];
        logic [BW-1:0] q;
        int n_tok;
        int i;
        int k;
        int b;
        if (style == STYLE_NOISE)
        begin
            n_tok = $urandom_range(20, 1);
            for (i = 0; i < n_tok; i++)
                push_byte(BW'($urandom_range(255)));
            push_end();
            return;
        end
        n_tok = $urandom_range(10, 1);
        for (i = 0; i < n_tok; i++)
        begin
            case ($urandom_range(8))
                0, 1, 2:
                begin
                    for (k = $urandom_range(6, 1); k > 0; k--)
                    begin
                        if ($urandom_range(9) == 0)
                        begin
                            push_byte(qbt_pkg::CH_BACKSLASH);
                            push_byte(BW'($urandom_range(255)));
                        end
                        else
                        begin
                            push_byte(word_byte());
                        end
                    end
                end
                3:
                    for (k = $urandom_range(3, 1); k > 0; k--)
                        push_byte(blank_pick());
                4:
                    push_byte(mark_pick());
                5:
                begin
                    b = $urandom_range(2);
                    push_byte(opener_set[b]);
                    closers.push_back(closer_set[b]);
                end
                6:
                    push_byte(closers.size() != 0 ? closers.pop_back() : mark_pick());
                7:
                begin
                    // Quoted run whose content never holds its own quote bare
                    q = $urandom_range(1) ? qbt_pkg::CH_DQUOTE : qbt_pkg::CH_SQUOTE;
                    push_byte(q);
                    for (k = $urandom_range(6); k > 0; k--)
                    begin
                        case ($urandom_range(5))
                            0: push_byte(blank_pick());
                            1: push_byte(mark_pick());
                            2: push_byte(stray_set[$urandom_range(8, 3)]);
                            3: push_byte(q == qbt_pkg::CH_DQUOTE ? qbt_pkg::CH_SQUOTE
                                                                 : qbt_pkg::CH_DQUOTE);
                            4:
                            begin
                                push_byte(qbt_pkg::CH_BACKSLASH);
                                push_byte(q);
                            end
                            default: push_byte(word_byte());
                        endcase
                    end
                    push_byte(q);
                end
                default:
                begin
                    push_byte(qbt_pkg::CH_BACKSLASH);
                    push_byte(BW'($urandom_range(255)));
                end
            endcase
            if (style == STYLE_BROKEN && $urandom_range(3) == 0)
                push_byte(stray_set[$urandom_range(8)]);
        end
        if (style == STYLE_CLEAN || $urandom_range(1))
            while (closers.size() != 0)
                push_byte(closers.pop_back());
        push_end();
    endtask

    // Hold the sender until every request is taken and every token is back
    task automatic await_drain();
        while (requests_taken != requests_sent || tokens_due.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        int src_pct[4];
        int out_pct[4];
        int ph;
        int target;
        int sel;
        int i;
        src_pct = '{0, 58, 0, 28};
        out_pct = '{0, 0, 58, 28};
        requests_sent = 0;
        requests_taken = 0;
        req_taken = 1'b0;
        mismatches = 0;
        src_idle_pct = 0;
        out_stall_pct = 0;
        clear_state();

        // Directed strings
        push_end();
        push_text(" a  b;");
        push_text("\t\"x y\"(");
        push_text("'a");
        push_text("\"'");
        push_text("}");
        push_text("\\(\\");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_end();

        // Random strings in phases of different idling
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            await_drain();
            src_idle_pct = src_pct[ph % 4];
            out_stall_pct = out_pct[ph % 4];
            if (ph == 5)
            begin
                // Bracket depths pushed past both signed limits
                for (i = 0; i < 2 ** DEPTH_W / 2 + 4; i++)
                    push_byte(qbt_pkg::CH_RND_OPEN);
                push_end();
                for (i = 0; i < 2 ** DEPTH_W / 2 + 4; i++)
                    push_byte(qbt_pkg::CH_RND_CLOSE);
                push_end();
            end
            target = requests_sent + PHASE_ITEMS;
            while (requests_sent < target)
            begin
                sel = $urandom_range(9);
                if (sel < 7)
                    push_phrase(STYLE_CLEAN);
                else if (sel < 9)
                    push_phrase(STYLE_BROKEN);
                else
                    push_phrase(STYLE_NOISE);
            end
        end

        await_drain();
        repeat (10) @(posedge clk);
        if (tokens_due.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("[quote_bracket_aware_word_tokenizer] OK");
        else
            $display("[quote_bracket_aware_word_tokenizer] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("[quote_bracket_aware_word_tokenizer] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qbt_pkg.sv
design/qbt_if.sv
design/qbt_in_stage.sv
design/qbt_engine.sv
design/quote_bracket_aware_word_tokenizer.sv
test/quote_bracket_aware_word_tokenizer_test.sv
